>>> hw/rtl/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
// Used by mtep_decode and midi_track_event_parser_unit; depends on nothing.
`default_nettype none

package mtep_pkg;

    localparam int ABS_TIME_BITS_DEF = 32;
    localparam int DELTA_BITS        = 28;
    localparam int PARAM_BYTES       = 5;

    // status and meta type codes
    localparam logic [7:0] META_STATUS  = 8'hFF;
    localparam logic [7:0] META_PREFIX  = 8'h20;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_SMPTE   = 8'h54;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;
    localparam logic [7:0] TEXT_TYPE_LO = 8'h01;
    localparam logic [7:0] TEXT_TYPE_HI = 8'h0F;
    localparam logic [3:0] CH_STATUS_LO = 4'h8;
    localparam logic [3:0] CH_STATUS_HI = 4'hE;
    localparam logic [3:0] CH_PROGRAM   = 4'hC;
    localparam logic [3:0] CH_CHANPRESS = 4'hD;
    localparam logic [2:0] DELTA_MAX_BYTES = 3'd4;

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_CHDATA = 8'b0000_0100,
        PH_MTYPE  = 8'b0000_1000,
        PH_MLEN   = 8'b0001_0000,
        PH_MDATA  = 8'b0010_0000,
        PH_TEXT   = 8'b0100_0000,
        PH_SKIP   = 8'b1000_0000
    } phase_t;

    typedef enum logic [3:0] {
        KIND_NOTEOFF   = 4'd0,
        KIND_NOTEON    = 4'd1,
        KIND_KEYPRESS  = 4'd2,
        KIND_CONTROL   = 4'd3,
        KIND_PROGRAM   = 4'd4,
        KIND_CHANPRESS = 4'd5,
        KIND_PITCH     = 4'd6,
        KIND_TEXTHDR   = 4'd7,
        KIND_TEXTBYTE  = 4'd8,
        KIND_PREFIX    = 4'd9,
        KIND_EOT       = 4'd10,
        KIND_TEMPO     = 4'd11,
        KIND_SMPTE     = 4'd12,
        KIND_TIMESIG   = 4'd13,
        KIND_KEYSIG    = 4'd14,
        KIND_ERROR     = 4'd15
    } kind_t;

    typedef struct packed {
        phase_t                           phase;
        logic [DELTA_BITS-1:0]            delta_accum;
        logic [2:0]                       delta_bytes;
        logic [7:0]                       status_hold;
        logic [7:0]                       meta_type;
        logic [7:0]                       meta_length;
        logic [7:0]                       byte_count;
        logic [PARAM_BYTES-1:0][7:0]      params;
    } parse_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [3:0]            channel;
        logic [DELTA_BITS-1:0] delta_time;
        logic [31:0]           abs_time;
        logic [7:0]            byte_a;
        logic [7:0]            byte_b;
        logic [7:0]            byte_c;
        logic [7:0]            byte_d;
        logic [7:0]            byte_e;
        logic                  text_last;
    } record_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:       PH_DELTA,
        delta_accum: '0,
        delta_bytes: '0,
        status_hold: '0,
        meta_type:   '0,
        meta_length: '0,
        byte_count:  '0,
        params:      '0
    };

endpackage

`default_nettype wire

>>> hw/rtl/mtep_decode.sv
// Per-word next-state and record logic of the MIDI track event parser.
// Purely combinational; depends on mtep_pkg.
`default_nettype none

module mtep_decode #(
    parameter int ABS_TIME_BITS = mtep_pkg::ABS_TIME_BITS_DEF
) (
    input  wire logic [7:0]               data_byte,
    input  wire logic                     track_start,
    input  wire mtep_pkg::parse_state_t   state_cur,
    input  wire logic [ABS_TIME_BITS-1:0] time_cur,
    output mtep_pkg::parse_state_t        state_next,
    output logic [ABS_TIME_BITS-1:0]      time_next,
    output logic                          rec_valid,
    output mtep_pkg::record_t             rec
);

    mtep_pkg::parse_state_t                  cur;
    logic [ABS_TIME_BITS-1:0]                tcur;
    logic [ABS_TIME_BITS+31:0]               t_ext;
    logic [mtep_pkg::DELTA_BITS-1:0]         accum_new;
    logic [2:0]                              bytes_inc;
    logic [7:0]                              cnt_inc;
    logic [ABS_TIME_BITS+mtep_pkg::DELTA_BITS-1:0] sum_ext;
    logic [3:0]                              hi_in;
    logic [3:0]                              hi_held;
    logic                                    one_data;
    logic                                    is_text;
    logic [mtep_pkg::PARAM_BYTES-1:0][7:0]   p_upd;

    function automatic mtep_pkg::parse_state_t next_event(input mtep_pkg::parse_state_t s);
        mtep_pkg::parse_state_t r;
        r             = s;
        r.phase       = mtep_pkg::PH_DELTA;
        r.delta_accum = '0;
        r.delta_bytes = '0;
        r.byte_count  = '0;
        return r;
    endfunction

    function automatic logic meta_len_ok(input logic [7:0] t, input logic [7:0] len);
        logic ok;
        case (t)
            mtep_pkg::META_PREFIX:  ok = (len == 8'd1);
            mtep_pkg::META_EOT:     ok = (len == 8'd0);
            mtep_pkg::META_TEMPO:   ok = (len == 8'd3);
            mtep_pkg::META_SMPTE:   ok = (len == 8'd5);
            mtep_pkg::META_TIMESIG: ok = (len == 8'd4);
            mtep_pkg::META_KEYSIG:  ok = (len == 8'd2);
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

    // fills kind and parameter bytes of a meta record; other fields kept
    function automatic mtep_pkg::record_t meta_fill(
        input mtep_pkg::record_t r_in,
        input logic [7:0] t,
        input logic [mtep_pkg::PARAM_BYTES-1:0][7:0] p
    );
        mtep_pkg::record_t r;
        r = r_in;
        case (t)
            mtep_pkg::META_PREFIX: begin
                r.kind   = mtep_pkg::KIND_PREFIX;
                r.byte_a = p[0];
            end
            mtep_pkg::META_EOT: begin
                r.kind = mtep_pkg::KIND_EOT;
            end
            mtep_pkg::META_TEMPO: begin
                r.kind   = mtep_pkg::KIND_TEMPO;
                r.byte_a = p[0];
                r.byte_b = p[1];
                r.byte_c = p[2];
            end
            mtep_pkg::META_SMPTE: begin
                r.kind   = mtep_pkg::KIND_SMPTE;
                r.byte_a = p[0];
                r.byte_b = p[1];
                r.byte_c = p[2];
                r.byte_d = p[3];
                r.byte_e = p[4];
            end
            mtep_pkg::META_TIMESIG: begin
                r.kind   = mtep_pkg::KIND_TIMESIG;
                r.byte_a = p[0];
                r.byte_b = p[1];
                r.byte_c = p[2];
                r.byte_d = p[3];
            end
            default: begin
                r.kind   = mtep_pkg::KIND_KEYSIG;
                r.byte_a = p[0];
                r.byte_b = p[1];
            end
        endcase
        return r;
    endfunction

    always_comb begin
        // track start clears everything before this word is parsed
        cur  = track_start ? mtep_pkg::PARSE_STATE_RESET : state_cur;
        tcur = track_start ? '0 : time_cur;

        t_ext     = {32'b0, tcur};
        accum_new = {cur.delta_accum[mtep_pkg::DELTA_BITS-8:0], data_byte[6:0]};
        bytes_inc = cur.delta_bytes + 3'd1;
        cnt_inc   = cur.byte_count + 8'd1;
        sum_ext   = {{mtep_pkg::DELTA_BITS{1'b0}}, tcur}
                  + {{ABS_TIME_BITS{1'b0}}, accum_new};
        hi_in     = data_byte[7:4];
        hi_held   = cur.status_hold[7:4];
        one_data  = (hi_held == mtep_pkg::CH_PROGRAM) || (hi_held == mtep_pkg::CH_CHANPRESS);
        is_text   = (cur.meta_type >= mtep_pkg::TEXT_TYPE_LO)
                 && (cur.meta_type <= mtep_pkg::TEXT_TYPE_HI);

        state_next = cur;
        time_next  = tcur;
        rec_valid  = 1'b0;
        rec            = '0;
        rec.delta_time = cur.delta_accum;
        rec.abs_time   = t_ext[31:0];
        p_upd          = cur.params;

        case (cur.phase)
            mtep_pkg::PH_DELTA: begin
                state_next.delta_accum = accum_new;
                state_next.delta_bytes = bytes_inc;
                if (!data_byte[7] || bytes_inc >= mtep_pkg::DELTA_MAX_BYTES) begin
                    time_next        = sum_ext[ABS_TIME_BITS-1:0];
                    state_next.phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (data_byte == mtep_pkg::META_STATUS) begin
                    state_next.phase = mtep_pkg::PH_MTYPE;
                end else if (hi_in >= mtep_pkg::CH_STATUS_LO
                             && hi_in <= mtep_pkg::CH_STATUS_HI) begin
                    state_next.status_hold = data_byte;
                    state_next.byte_count  = '0;
                    state_next.phase       = mtep_pkg::PH_CHDATA;
                end else begin
                    // running status, SysEx and system messages
                    rec_valid  = 1'b1;
                    rec.kind   = mtep_pkg::KIND_ERROR;
                    rec.byte_a = data_byte;
                    state_next = next_event(cur);
                end
            end
            mtep_pkg::PH_CHDATA: begin
                p_upd[{2'b00, cur.byte_count[0]}] = data_byte;
                state_next.params        = p_upd;
                state_next.byte_count    = cnt_inc;
                if (one_data || cnt_inc >= 8'd2) begin
                    rec_valid   = 1'b1;
                    rec.kind    = mtep_pkg::kind_t'({1'b0, hi_held[2:0]});
                    rec.channel = cur.status_hold[3:0];
                    rec.byte_a  = p_upd[0];
                    rec.byte_b  = one_data ? 8'd0 : p_upd[1];
                    state_next  = next_event(state_next);
                end
            end
            mtep_pkg::PH_MTYPE: begin
                state_next.meta_type = data_byte;
                state_next.phase     = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
                state_next.meta_length = data_byte;
                state_next.byte_count  = '0;
                if (is_text) begin
                    rec_valid  = 1'b1;
                    rec.kind   = mtep_pkg::KIND_TEXTHDR;
                    rec.byte_a = cur.meta_type;
                    rec.byte_b = data_byte;
                    if (data_byte == 8'd0) begin
                        state_next = next_event(state_next);
                    end else begin
                        state_next.phase = mtep_pkg::PH_TEXT;
                    end
                end else if (meta_len_ok(cur.meta_type, data_byte)) begin
                    if (data_byte == 8'd0) begin
                        rec_valid  = 1'b1;
                        rec        = meta_fill(rec, cur.meta_type, cur.params);
                        state_next = next_event(state_next);
                    end else begin
                        state_next.phase = mtep_pkg::PH_MDATA;
                    end
                end else if (data_byte == 8'd0) begin
                    state_next = next_event(state_next);
                end else begin
                    state_next.phase = mtep_pkg::PH_SKIP;
                end
            end
            mtep_pkg::PH_MDATA: begin
                // length was checked, so the count stays below five here
                if (cur.byte_count < 8'(mtep_pkg::PARAM_BYTES)) begin
                    p_upd[cur.byte_count[2:0]] = data_byte;
                end
                state_next.params     = p_upd;
                state_next.byte_count = cnt_inc;
                if (cnt_inc >= cur.meta_length) begin
                    rec_valid  = 1'b1;
                    rec        = meta_fill(rec, cur.meta_type, p_upd);
                    state_next = next_event(state_next);
                end
            end
            mtep_pkg::PH_TEXT: begin
                state_next.byte_count = cnt_inc;
                rec_valid             = 1'b1;
                rec.kind              = mtep_pkg::KIND_TEXTBYTE;
                rec.byte_a            = data_byte;
                if (cnt_inc >= cur.meta_length) begin
                    rec.text_last = 1'b1;
                    state_next    = next_event(state_next);
                end
            end
            mtep_pkg::PH_SKIP: begin
                state_next.byte_count = cnt_inc;
                if (cnt_inc >= cur.meta_length) begin
                    state_next = next_event(state_next);
                end
            end
            default: begin
                state_next = next_event(cur);
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/midi_track_event_parser_unit.sv
// MIDI track event parser: takes one track chunk byte per word on s_ and
// gives at most one event record per byte on m_. A byte is accepted in every
// cycle while the result register is free or being drained; its record, if
// any, shows on m_ in the cycle after acceptance. The rate is one byte per
// cycle while m_ does not stall, since mtep_decode forms the next parser
// state combinationally. s_track_start clears the parser and the absolute
// time before its byte is parsed. Depends on mtep_pkg and mtep_decode.
`default_nettype none

module midi_track_event_parser_unit #(
    parameter int ABS_TIME_BITS = mtep_pkg::ABS_TIME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_track_start,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_kind,
    output logic [3:0]       m_channel,
    output logic [27:0]      m_delta_time,
    output logic [31:0]      m_abs_time,
    output logic [7:0]       m_byte_a,
    output logic [7:0]       m_byte_b,
    output logic [7:0]       m_byte_c,
    output logic [7:0]       m_byte_d,
    output logic [7:0]       m_byte_e,
    output logic             m_text_last
);

    mtep_pkg::parse_state_t    state_reg, state_next;
    logic [ABS_TIME_BITS-1:0]  time_reg, time_next;
    logic                      rec_valid;
    mtep_pkg::record_t         rec, rec_reg;
    logic                      m_valid_reg;
    logic                      accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mtep_decode #(
        .ABS_TIME_BITS(ABS_TIME_BITS)
    ) u_decode (
        .data_byte  (s_data_byte),
        .track_start(s_track_start),
        .state_cur  (state_reg),
        .time_cur   (time_reg),
        .state_next (state_next),
        .time_next  (time_next),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtep_pkg::PARSE_STATE_RESET;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                time_reg  <= time_next;
            end
            if (s_ready) begin
                m_valid_reg <= accept && rec_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && rec_valid) begin
            rec_reg <= rec;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = rec_reg.kind;
    assign m_channel    = rec_reg.channel;
    assign m_delta_time = rec_reg.delta_time;
    assign m_abs_time   = rec_reg.abs_time;
    assign m_byte_a     = rec_reg.byte_a;
    assign m_byte_b     = rec_reg.byte_b;
    assign m_byte_c     = rec_reg.byte_c;
    assign m_byte_d     = rec_reg.byte_d;
    assign m_byte_e     = rec_reg.byte_e;
    assign m_text_last  = rec_reg.text_last;

    // a delta never spans more than four bytes
    a_delta_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.delta_bytes <= mtep_pkg::DELTA_MAX_BYTES)
        else $error("delta byte count out of range");

    // inside a text event there is always at least one byte to come
    a_text_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == mtep_pkg::PH_TEXT)
        |-> (state_reg.byte_count < state_reg.meta_length))
        else $error("text phase with no bytes left");

    // a produced record shows up on the result port next cycle
    a_record_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && rec_valid) |=> (m_valid && m_kind == $past(rec.kind)))
        else $error("record lost in result register");

    // the last text byte closes the event
    a_text_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && rec_valid && rec.text_last)
        |=> (state_reg.phase == mtep_pkg::PH_DELTA && state_reg.byte_count == 8'd0))
        else $error("text event not closed after last byte");

endmodule

`default_nettype wire
